FILE: design/largest_remainder_seat_apportion_defines.svh
// ----------------------------------------------------------------------------
// largest_remainder_seat_apportion_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef LARGEST_REMAINDER_SEAT_APPORTION_DEFINES_SVH
`define LARGEST_REMAINDER_SEAT_APPORTION_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define LRSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LRSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: design/lrsa_pkg.sv
// ----------------------------------------------------------------------------
// lrsa_pkg
// Shared constants and types for the seat apportionment block.
// ----------------------------------------------------------------------------
package lrsa_pkg;
    localparam int MaxMembersDef = 16;
    localparam int IdW     = 6;
    localparam int WeightW = 24;
    localparam int SeatW   = 8;
    localparam int SumW    = 30;
    localparam int ProdW   = WeightW + SeatW;

    typedef struct packed {
        logic load;
        logic clear;
        logic div_start;
        logic wr_seat;
        logic wr_rem;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;
endpackage

FILE: design/largest_remainder_seat_apportion.sv
// ----------------------------------------------------------------------------
// largest_remainder_seat_apportion
// Largest remainder seat apportionment over a loaded set of members.
// ----------------------------------------------------------------------------
// Usage: transfer members on the input channel (id, weight, last), one per
// cycle while o_in_ready is high. Zero-weight members are dropped; members
// past MaxMembers are dropped. The transfer carrying last closes the set;
// o_in_ready then falls until the final result enters the output register.
// After last the sequencer sorts the members by weight, sets up the base
// seats, multiplies and serially divides for each member in turn, sorts by
// remainder, distributes the leftover seats, then emits one result per
// cycle while the output register is free. The serial divider takes most
// of the time. An empty set gives one result with o_empty_res set.
// Results come from an output register; a stalled receiver holds the result
// and the sequencer waits. Reset is synchronous, active low; it clears the
// sequencer and loads seat_total with 80. Write i_cfg_we only while idle.
// ----------------------------------------------------------------------------
module largest_remainder_seat_apportion import lrsa_pkg::*; #(
    parameter int MaxMembers = MaxMembersDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SeatW-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [IdW-1:0]     i_member_id,
    input  logic [WeightW-1:0] i_weight,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [IdW-1:0]     o_out_member_id,
    output logic [SeatW-1:0]   o_seats,
    output logic               o_out_last,
    output logic               o_empty_res
);
    localparam int IdxW = $clog2(MaxMembers);
    logic [SeatW-1:0] r_seat_total;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic [IdxW-1:0] w_wr_idx, w_ra, w_rb;
    logic w_swap_w, w_swap_p, w_gt_w, w_gt_r, w_seat_inc, w_sum_zero;
    logic [SeatW-1:0] w_pool, w_base, w_extra, w_seat;
    logic [IdW-1:0] w_id;
    logic w_emit, w_emit_empty, w_emit_last, w_free;
    logic r_ov, r_last, r_empty;
    logic [IdW-1:0] r_oid;
    logic [SeatW-1:0] r_oseat;

    // hold the seat count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seat_total <= SeatW'(80);
        else if (i_cfg_we) r_seat_total <= i_cfg_wdata;
    end

    assign w_free = !r_ov || i_out_ready;

    lrsa_ctrl #(.MaxMembers(MaxMembers)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_seat_total(r_seat_total),
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_weight(i_weight),
        .i_last(i_last), .i_sts(w_sts), .i_gt_w(w_gt_w), .i_gt_r(w_gt_r),
        .i_extra(w_extra), .i_sum_zero(w_sum_zero), .o_cmd(w_cmd),
        .o_wr_idx(w_wr_idx), .o_ra(w_ra), .o_rb(w_rb), .o_swap_w(w_swap_w),
        .o_swap_p(w_swap_p), .o_pool(w_pool), .o_seat_base(w_base),
        .o_seat_inc(w_seat_inc), .o_emit(w_emit), .o_emit_empty(w_emit_empty),
        .o_emit_last(w_emit_last), .i_out_free(w_free)
    );

    lrsa_datapath #(.MaxMembers(MaxMembers)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_wr_idx(w_wr_idx),
        .i_ra(w_ra), .i_rb(w_rb), .i_swap_w(w_swap_w), .i_swap_p(w_swap_p),
        .i_pool(w_pool), .i_seat_base(w_base), .i_seat_inc(w_seat_inc),
        .i_id(i_member_id), .i_weight(i_weight), .o_sts(w_sts),
        .o_gt_w(w_gt_w), .o_gt_r(w_gt_r), .o_extra(w_extra),
        .o_sum_zero(w_sum_zero), .o_id(w_id), .o_seat(w_seat)
    );

    // output register: advance on emit, drop valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
        if (w_emit) begin
            r_oid   <= w_emit_empty ? '0 : w_id;
            r_oseat <= w_emit_empty ? '0 : w_seat;
            r_last  <= w_emit_empty ? 1'b1 : w_emit_last;
            r_empty <= w_emit_empty;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_member_id = r_oid;
    assign o_seats = r_oseat;
    assign o_out_last = r_last;
    assign o_empty_res = r_empty;
endmodule

FILE: design/lrsa_div.sv
// ----------------------------------------------------------------------------
// lrsa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrsa_div import lrsa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ProdW-1:0] i_num,
    input  logic [SumW-1:0]  i_den,
    output logic             o_done,
    output logic [ProdW-1:0] o_quo,
    output logic [SumW-1:0]  o_rem
);
    localparam int CntW = $clog2(ProdW + 1);
    logic [ProdW-1:0] r_q, n_q;
    logic [SumW:0]    r_r, n_r;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [SumW:0]    w_sh;

    always_comb begin
        n_q = r_q; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_sh = {r_r[SumW-1:0], r_q[ProdW-1]};
        if (i_start) begin
            n_q = i_num; n_r = '0; n_cnt = CntW'(ProdW); n_busy = 1'b1;
        end else if (r_busy) begin
            n_q = {r_q[ProdW-2:0], 1'b0};
            if (w_sh >= {1'b0, i_den}) begin
                n_r = w_sh - {1'b0, i_den};
                n_q[0] = 1'b1;
            end else begin
                n_r = w_sh;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r[SumW-1:0];
endmodule

FILE: design/lrsa_datapath.sv
// ----------------------------------------------------------------------------
// lrsa_datapath
// Member stores, weight sum, sort compare, multiply, and divider.
// ----------------------------------------------------------------------------
module lrsa_datapath import lrsa_pkg::*; #(
    parameter int MaxMembers = MaxMembersDef,
    parameter int IdxW = $clog2(MaxMembers)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [IdxW-1:0]    i_wr_idx,
    input  logic [IdxW-1:0]    i_ra,
    input  logic [IdxW-1:0]    i_rb,
    input  logic               i_swap_w,
    input  logic               i_swap_p,
    input  logic [SeatW-1:0]   i_pool,
    input  logic [SeatW-1:0]   i_seat_base,
    input  logic               i_seat_inc,
    input  logic [IdW-1:0]     i_id,
    input  logic [WeightW-1:0] i_weight,
    output t_dp_sts            o_sts,
    output logic               o_gt_w,
    output logic               o_gt_r,
    output logic [SeatW-1:0]   o_extra,
    output logic               o_sum_zero,
    output logic [IdW-1:0]     o_id,
    output logic [SeatW-1:0]   o_seat
);
    logic [IdW-1:0]     r_id  [MaxMembers];
    logic [WeightW-1:0] r_w   [MaxMembers];
    logic [SeatW-1:0]   r_st  [MaxMembers];
    logic [SumW-1:0]    r_rem [MaxMembers];
    logic [IdxW-1:0]    r_pos [MaxMembers];
    logic [SumW-1:0]    r_sum;
    logic [ProdW-1:0]   r_prod;
    logic               w_done;
    logic [ProdW-1:0]   w_quo;
    logic [SumW-1:0]    w_rem;
    logic [IdxW-1:0]    w_pa, w_pb;

    assign w_pa = r_pos[i_ra];
    assign w_pb = r_pos[i_rb];
    // member a ranks below member b (weight desc, id asc)
    assign o_gt_w = (r_w[i_ra] < r_w[i_rb]) ||
                    (r_w[i_ra] == r_w[i_rb] && r_id[i_ra] > r_id[i_rb]);
    assign o_gt_r = (r_rem[w_pa] < r_rem[w_pb]) ||
                    (r_rem[w_pa] == r_rem[w_pb] && r_id[w_pa] > r_id[w_pb]);
    assign o_sum_zero = (r_sum == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.clear) begin
            r_sum <= '0;
        end else if (i_cmd.load) begin
            r_sum <= r_sum + SumW'(i_weight);
        end
        r_prod <= r_w[i_ra] * i_pool;
        if (i_cmd.load) begin
            r_id[i_wr_idx] <= i_id;
            r_w[i_wr_idx]  <= i_weight;
            r_pos[i_wr_idx] <= i_wr_idx;
        end
        if (i_swap_w) begin
            r_id[i_ra] <= r_id[i_rb]; r_id[i_rb] <= r_id[i_ra];
            r_w[i_ra]  <= r_w[i_rb];  r_w[i_rb]  <= r_w[i_ra];
        end
        if (i_swap_p) begin
            r_pos[i_ra] <= w_pb; r_pos[i_rb] <= w_pa;
        end
        if (i_cmd.wr_rem) begin
            r_st[i_ra]  <= i_seat_base + w_quo[SeatW-1:0];
            r_rem[i_ra] <= w_rem;
        end
        if (i_cmd.wr_seat) begin
            r_st[w_pa] <= r_st[w_pa] + SeatW'(i_seat_inc);
        end
    end

    lrsa_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (r_prod),
        .i_den  (r_sum),
        .o_done (w_done),
        .o_quo  (w_quo),
        .o_rem  (w_rem)
    );

    assign o_sts.div_done = w_done;
    assign o_extra = w_quo[SeatW-1:0];
    assign o_id    = r_id[i_ra];
    assign o_seat  = r_st[i_ra];
endmodule

FILE: design/lrsa_ctrl.sv
// ----------------------------------------------------------------------------
// lrsa_ctrl
// Sequencer: load, sort, divide, distribute, emit.
// ----------------------------------------------------------------------------
module lrsa_ctrl import lrsa_pkg::*; #(
    parameter int MaxMembers = MaxMembersDef,
    parameter int IdxW = $clog2(MaxMembers)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SeatW-1:0] i_seat_total,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WeightW-1:0] i_weight,
    input  logic             i_last,
    input  t_dp_sts          i_sts,
    input  logic             i_gt_w,
    input  logic             i_gt_r,
    input  logic [SeatW-1:0] i_extra,
    input  logic             i_sum_zero,
    output t_dp_cmd          o_cmd,
    output logic [IdxW-1:0]  o_wr_idx,
    output logic [IdxW-1:0]  o_ra,
    output logic [IdxW-1:0]  o_rb,
    output logic             o_swap_w,
    output logic             o_swap_p,
    output logic [SeatW-1:0] o_pool,
    output logic [SeatW-1:0] o_seat_base,
    output logic             o_seat_inc,
    output logic             o_emit,
    output logic             o_emit_empty,
    output logic             o_emit_last,
    input  logic             i_out_free
);
    localparam logic [3:0] SLoad = 4'd0, SSortW = 4'd1, SMul = 4'd2, SMul2 = 4'd3,
        SDiv = 4'd4, SSortR = 4'd5, SDist = 4'd6, SEmit = 4'd7, SEmpty = 4'd8,
        SInit = 4'd9;
    localparam int CntW = IdxW + 1;

    logic [3:0]       r_st, n_st;
    logic [CntW-1:0]  r_n, n_n, r_i, n_i, r_j, n_j;
    logic [SeatW:0]   r_asg, n_asg;
    logic [SeatW-1:0] r_pool, n_pool, r_base, n_base;
    logic             w_acc, w_take;

    assign o_ready = (r_st == SLoad);
    assign w_acc = i_valid && o_ready;
    assign w_take = w_acc && (i_weight != '0) && (r_n < CntW'(MaxMembers));
    assign o_wr_idx = r_n[IdxW-1:0];
    assign o_pool = r_pool;
    assign o_seat_base = r_base;

    always_comb begin
        n_st = r_st; n_n = r_n; n_i = r_i; n_j = r_j; n_asg = r_asg;
        n_pool = r_pool; n_base = r_base;
        o_cmd = '0; o_swap_w = 1'b0; o_swap_p = 1'b0; o_seat_inc = 1'b0;
        o_ra = r_j[IdxW-1:0]; o_rb = r_j[IdxW-1:0];
        o_emit = 1'b0; o_emit_empty = 1'b0;
        o_emit_last = (r_i == r_n - 1'b1);
        o_cmd.load = w_take;
        case (r_st)
            SLoad: begin
                if (w_take) n_n = r_n + 1'b1;
                if (w_acc && i_last) begin
                    if (!w_take && (r_n == '0 || i_sum_zero)) n_st = SEmpty;
                    else begin n_st = SSortW; n_i = CntW'(1); n_j = CntW'(1); end
                end
            end
            SEmpty: begin
                if (i_out_free) begin
                    o_emit = 1'b1; o_emit_empty = 1'b1; o_cmd.clear = 1'b1;
                    n_n = '0; n_st = SLoad;
                end
            end
            SSortW: begin
                // insertion sort by adjacent swaps
                if (r_i >= r_n) begin
                    n_st = SInit;
                end else begin
                    o_ra = IdxW'(r_j - 1'b1); o_rb = r_j[IdxW-1:0];
                    if (r_j != '0 && i_gt_w) begin
                        o_swap_w = 1'b1; n_j = r_j - 1'b1;
                    end else begin
                        n_i = r_i + 1'b1; n_j = r_i + 1'b1;
                    end
                end
            end
            SInit: begin
                if ({1'b0, r_n} <= {1'b0, i_seat_total}) begin
                    n_asg = (SeatW+1)'(r_n); n_pool = i_seat_total - SeatW'(r_n);
                    n_base = SeatW'(1);
                end else begin
                    n_asg = '0; n_pool = i_seat_total; n_base = '0;
                end
                n_i = '0; n_st = SMul;
            end
            SMul: begin
                o_ra = r_i[IdxW-1:0]; n_st = SMul2;
            end
            SMul2: begin
                o_cmd.div_start = 1'b1; n_st = SDiv;
            end
            SDiv: begin
                o_ra = r_i[IdxW-1:0];
                if (i_sts.div_done) begin
                    o_cmd.wr_rem = 1'b1;
                    n_asg = r_asg + (SeatW+1)'(i_extra);
                    n_i = r_i + 1'b1;
                    if (r_i + 1'b1 == r_n) begin
                        n_st = SSortR; n_i = CntW'(1); n_j = CntW'(1);
                    end else n_st = SMul;
                end
            end
            SSortR: begin
                if (r_i >= r_n) begin
                    n_st = SDist; n_i = '0;
                end else begin
                    o_ra = IdxW'(r_j - 1'b1); o_rb = r_j[IdxW-1:0];
                    if (r_j != '0 && i_gt_r) begin
                        o_swap_p = 1'b1; n_j = r_j - 1'b1;
                    end else begin
                        n_i = r_i + 1'b1; n_j = r_i + 1'b1;
                    end
                end
            end
            SDist: begin
                o_ra = r_i[IdxW-1:0];
                if (r_asg < {1'b0, i_seat_total} && r_i < r_n) begin
                    o_cmd.wr_seat = 1'b1; o_seat_inc = 1'b1;
                    n_i = r_i + 1'b1; n_asg = r_asg + 1'b1;
                end else begin
                    n_i = '0; n_st = SEmit;
                end
            end
            SEmit: begin
                o_ra = r_i[IdxW-1:0];
                if (i_out_free) begin
                    o_emit = 1'b1; n_i = r_i + 1'b1;
                    if (r_i == r_n - 1'b1) begin
                        o_cmd.clear = 1'b1; n_n = '0; n_st = SLoad;
                    end
                end
            end
            default: n_st = SLoad;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SLoad; r_n <= '0; r_i <= '0; r_j <= '0; r_asg <= '0;
        end else begin
            r_st <= n_st; r_n <= n_n; r_i <= n_i; r_j <= n_j; r_asg <= n_asg;
        end
        r_pool <= n_pool; r_base <= n_base;
    end
endmodule

FILE: design/lrsa_checker.sv
// ----------------------------------------------------------------------------
// lrsa_checker
// Port-level checks on the apportionment block.
// ----------------------------------------------------------------------------
`include "largest_remainder_seat_apportion_defines.svh"
module lrsa_checker import lrsa_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [SeatW-1:0] o_seats,
    input logic             o_out_last,
    input logic             o_empty_res
);
    logic w_out_stall;
    logic w_empty_out;

    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_empty_out = o_out_valid && o_empty_res;

    `LRSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_out_valid && $stable(o_seats))
    `LRSA_ASSERT_IMP(a_empty_last, i_clk, i_rst_n, w_empty_out, o_out_last && o_seats == '0)
    `LRSA_ASSERT_IMP(a_no_load_out, i_clk, i_rst_n, o_in_ready && o_out_valid, o_out_last)
endmodule

bind largest_remainder_seat_apportion lrsa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_seats(o_seats),
    .o_out_last(o_out_last), .o_empty_res(o_empty_res)
);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the largest remainder seat apportionment block.
// Sends member sets over the input channel, predicts every result with its
// own apportionment model, and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module testbench import lrsa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxM        = MaxMembersDef;
    localparam int SettleCycles = 800;

    typedef struct {
        logic [IdW-1:0]   member_id;
        logic [SeatW-1:0] seats;
        logic             last;
        logic             empty;
    } t_seat_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [SeatW-1:0]   i_cfg_wdata = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [IdW-1:0]     i_member_id = '0;
    logic [WeightW-1:0] i_weight    = '0;
    logic               i_last      = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [IdW-1:0]     o_out_member_id;
    logic [SeatW-1:0]   o_seats;
    logic               o_out_last;
    logic               o_empty_res;

    largest_remainder_seat_apportion uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_member_id     (i_member_id),
        .i_weight        (i_weight),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_member_id (o_out_member_id),
        .o_seats         (o_seats),
        .o_out_last      (o_out_last),
        .o_empty_res     (o_empty_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: the set being loaded and the seat total in force.
    logic [IdW-1:0]     set_ids [MaxM];
    logic [WeightW-1:0] set_wts [MaxM];
    int                 set_count = 0;
    longint             set_sum   = 0;
    int                 seat_total_mdl = 80;

    t_seat_result       seat_result_q[$];
    int                 fail_count  = 0;
    int                 mism_count  = 0;
    int                 items_sent  = 0;
    bit                 no_idle     = 1'b0;
    int                 holdoff_cycles = 0;
    logic [IdW-1:0]     prev_id = '0;
    logic [WeightW-1:0] prev_wt = 24'd1;

    // Load one accepted member; on last, apportion the set and queue results.
    function automatic void apportion_member(logic [IdW-1:0] id, logic [WeightW-1:0] w,
                                             logic lst);
        int n, i, j, k, pool, assigned;
        longint scaled;
        int seat_cnt [MaxM];
        longint rem [MaxM];
        int pos [MaxM];
        logic [IdW-1:0] kid;
        logic [WeightW-1:0] kw;
        t_seat_result r;
        if (w != 0 && set_count < MaxM) begin
            set_ids[set_count] = id;
            set_wts[set_count] = w;
            set_count++;
            set_sum += w;
        end
        if (!lst) return;
        n = set_count;
        set_count = 0;
        if (n == 0) begin
            r = '{member_id: '0, seats: '0, last: 1'b1, empty: 1'b1};
            seat_result_q.push_back(r);
            set_sum = 0;
            return;
        end
        // Stable sort: heavier first, smaller id first on equal weight.
        for (i = 1; i < n; i++) begin
            kid = set_ids[i];
            kw  = set_wts[i];
            j = i;
            while (j > 0 && (set_wts[j-1] < kw ||
                   (set_wts[j-1] == kw && set_ids[j-1] > kid))) begin
                set_ids[j] = set_ids[j-1];
                set_wts[j] = set_wts[j-1];
                j--;
            end
            set_ids[j] = kid;
            set_wts[j] = kw;
        end
        // Base seat per member only when every member can get one.
        if (n <= seat_total_mdl) begin
            for (i = 0; i < n; i++) seat_cnt[i] = 1;
            assigned = n;
            pool = seat_total_mdl - n;
        end else begin
            for (i = 0; i < n; i++) seat_cnt[i] = 0;
            assigned = 0;
            pool = seat_total_mdl;
        end
        for (i = 0; i < n; i++) begin
            scaled = longint'(set_wts[i]) * pool;
            seat_cnt[i] += int'(scaled / set_sum);
            assigned += int'(scaled / set_sum);
            rem[i] = scaled % set_sum;
            pos[i] = i;
        end
        // Rank by remainder, smaller id first on equal remainder.
        for (i = 1; i < n; i++) begin
            k = pos[i];
            j = i;
            while (j > 0 && (rem[pos[j-1]] < rem[k] ||
                   (rem[pos[j-1]] == rem[k] && set_ids[pos[j-1]] > set_ids[k]))) begin
                pos[j] = pos[j-1];
                j--;
            end
            pos[j] = k;
        end
        i = 0;
        while (assigned < seat_total_mdl && i < n) begin
            seat_cnt[pos[i]]++;
            i++;
            assigned++;
        end
        for (i = 0; i < n; i++) begin
            r.member_id = set_ids[i];
            r.seats     = seat_cnt[i][SeatW-1:0];
            r.last      = (i == n - 1);
            r.empty     = 1'b0;
            seat_result_q.push_back(r);
        end
        set_sum = 0;
    endfunction

    // Offer one member; hold valid and payload until the transfer happens.
    task automatic send_member(input logic [IdW-1:0] id, input logic [WeightW-1:0] w,
                               input logic lst);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_member_id <= id;
        i_weight    <= w;
        i_last      <= lst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        apportion_member(id, w, lst);
        items_sent++;
        prev_id = id;
        if (w != 0) prev_wt = w;
    endtask

    // Drop valid, wait for every queued result, then let the block go quiet.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (seat_result_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_seat_total(input int value);
        drain_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[SeatW-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        seat_total_mdl = value & 8'hFF;
    endtask

    // Random set: mostly positive weights, some zeros, ties and repeated ids.
    task automatic send_random_set(input int size);
        int i;
        logic [IdW-1:0] id;
        logic [WeightW-1:0] w;
        for (i = 0; i < size; i++) begin
            id = ($urandom_range(0, 7) == 0) ? prev_id : IdW'($urandom_range(0, 63));
            case ($urandom_range(0, 9))
                0: w = '0;
                1: w = prev_wt;
                2: w = '1;
                3, 4, 5: w = WeightW'($urandom_range(1, 255));
                default: w = WeightW'($urandom);
            endcase
            send_member(id, w, i == size - 1);
        end
    endtask

    function automatic int pick_seat_total();
        case ($urandom_range(0, 5))
            0: return 1;
            1: return 255;
            2: return $urandom_range(1, 15);
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    task automatic test_directed();
        // Extreme weights and ids at the default seat total.
        send_member(6'd0, 24'hFFFFFF, 1'b0);
        send_member(6'd63, 24'd1, 1'b1);
        // Set with no positive weight gives the empty result.
        send_member(6'd5, 24'd0, 1'b1);
        // Equal weights, duplicate ids, and a skipped member inside the set.
        send_member(6'd7, 24'd100, 1'b0);
        send_member(6'd3, 24'd100, 1'b0);
        send_member(6'd3, 24'd100, 1'b0);
        send_member(6'd9, 24'd0, 1'b0);
        send_member(6'd9, 24'd50, 1'b1);
        // More members than seats: no base seats.
        write_seat_total(2);
        send_member(6'd1, 24'd10, 1'b0);
        send_member(6'd2, 24'd10, 1'b0);
        send_member(6'd4, 24'd30, 1'b1);
        write_seat_total(0);
        send_member(6'd11, 24'd500, 1'b0);
        send_member(6'd12, 24'd700, 1'b1);
        write_seat_total(255);
        send_member(6'd42, 24'h800000, 1'b0);
        send_member(6'd21, 24'h7FFFFF, 1'b1);
        write_seat_total(1);
        send_member(6'd33, 24'h555555, 1'b1);
        drain_block();
    endtask

    // Overfill the member store with a couple of sets past capacity.
    task automatic test_store_full();
        write_seat_total(pick_seat_total());
        send_random_set(MaxM + 3);
        write_seat_total(255);
        send_random_set(MaxM + 1);
        drain_block();
    endtask

    task automatic test_random_sets();
        int start;
        start = items_sent;
        while (items_sent - start < 280) begin
            if ($urandom_range(0, 3) == 0) write_seat_total(pick_seat_total());
            send_random_set(($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                                        : $urandom_range(1, MaxM));
        end
        drain_block();
    endtask

    // Receiver holds off while the sender keeps offering full sets back to back.
    task automatic test_backpressure();
        no_idle = 1'b1;
        holdoff_cycles = 400;
        send_random_set(MaxM);
        send_random_set(MaxM);
        no_idle = 1'b0;
        drain_block();
    endtask

    task automatic test_no_idle();
        no_idle = 1'b1;
        write_seat_total(pick_seat_total());
        send_random_set(8);
        send_random_set(MaxM);
        no_idle = 1'b0;
        drain_block();
    endtask

    // Receiver: random stalls per result, and a long hold-off on request.
    initial begin : receiver
        int gap;
        forever begin
            if (holdoff_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (holdoff_cycles) @(posedge i_clk);
                holdoff_cycles = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_out_valid && i_out_ready)) @(posedge i_clk);
        end
    end

    // Compare every output transfer against the oldest expected result.
    always @(posedge i_clk) begin
        t_seat_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (seat_result_q.size() == 0) begin
                fail_count++;
                mism_count++;
                if (mism_count <= 10)
                    $display("unexpected result: id=%0d seats=%0d last=%0b empty=%0b",
                             o_out_member_id, o_seats, o_out_last, o_empty_res);
            end else begin
                exp_r = seat_result_q.pop_front();
                if (o_out_member_id !== exp_r.member_id || o_seats !== exp_r.seats ||
                    o_out_last !== exp_r.last || o_empty_res !== exp_r.empty) begin
                    fail_count++;
                    mism_count++;
                    if (mism_count <= 10)
                        $display("mismatch: exp id=%0d seats=%0d last=%0b empty=%0b",
                                 exp_r.member_id, exp_r.seats, exp_r.last, exp_r.empty,
                                 ", got id=%0d seats=%0d last=%0b empty=%0b",
                                 o_out_member_id, o_seats, o_out_last, o_empty_res);
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_store_full();
        test_random_sets();
        test_backpressure();
        test_no_idle();
        drain_block();
        if (seat_result_q.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+design
design/lrsa_pkg.sv
design/lrsa_div.sv
design/lrsa_datapath.sv
design/lrsa_ctrl.sv
design/largest_remainder_seat_apportion.sv
design/lrsa_checker.sv
tb/sv/testbench.sv
